// ===== rtl/iotp_pkg.sv =====
// package for the time-of-day parser: widths, phase codes, character codes
// and the result bundle passed from the scanner to the top level
// no dependencies
package iotp_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int COUNT_WIDTH = 8;
    localparam int DIGIT_WIDTH = 4;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] DIGIT_MAX  = 8'd9;

    localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {VALUE_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [2:0] {
        PH_HOUR_FIRST = 3'd0,
        PH_HOUR_MORE  = 3'd1,
        PH_MIN_FIRST  = 3'd2,
        PH_MIN_MORE   = 3'd3,
        PH_SEC_FIRST  = 3'd4,
        PH_SEC_MORE   = 3'd5,
        PH_IDLE       = 3'd6
    } t_phase;

    typedef struct packed {
        logic                   emit;
        logic                   ok;
        logic [VALUE_WIDTH-1:0] hours;
        logic [VALUE_WIDTH-1:0] minutes;
        logic [VALUE_WIDTH-1:0] seconds;
        logic [COUNT_WIDTH-1:0] count;
    } t_result;

endpackage

// ===== rtl/iotp_digit_acc.sv =====
// saturating decimal accumulate step: acc * 10 + digit, clipped at all ones
// depends on iotp_pkg
module iotp_digit_acc (
    input  logic [iotp_pkg::VALUE_WIDTH-1:0] i_acc,
    input  logic [iotp_pkg::DIGIT_WIDTH-1:0] i_digit,
    output logic [iotp_pkg::VALUE_WIDTH-1:0] o_acc
);

    localparam int PW = iotp_pkg::VALUE_WIDTH + 4;
    localparam int SW = PW + 1;

    logic [PW-1:0] times_ten;
    logic [SW-1:0] sum;

    // acc * 10 as (acc << 3) + (acc << 1)
    assign times_ten = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0};
    assign sum       = {1'b0, times_ten} + {{(SW - iotp_pkg::DIGIT_WIDTH){1'b0}}, i_digit};

    // clip when anything lands above the value width
    assign o_acc = (sum[SW-1:iotp_pkg::VALUE_WIDTH] != '0) ? iotp_pkg::VALUE_MAX
                                                           : sum[iotp_pkg::VALUE_WIDTH-1:0];

endmodule

// ===== rtl/iotp_scan.sv =====
// scan state machine: phase, value accumulators and byte count
// depends on iotp_pkg and iotp_digit_acc
module iotp_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_begin_req,
    output iotp_pkg::t_result     o_result
);

    localparam int VW = iotp_pkg::VALUE_WIDTH;
    localparam int CW = iotp_pkg::COUNT_WIDTH;
    localparam int DW = iotp_pkg::DIGIT_WIDTH;

    iotp_pkg::t_phase r_phase, n_phase, cur_phase;
    logic [VW-1:0] r_hour, n_hour, cur_hour;
    logic [VW-1:0] r_min,  n_min,  cur_min;
    logic [VW-1:0] r_sec,  n_sec,  cur_sec;
    logic [CW-1:0] r_count, n_count, cur_count, bumped;

    logic [7:0]    diff;
    logic          is_digit;
    logic          is_colon;
    logic [DW-1:0] digit;
    logic [VW-1:0] digit_ext;
    logic [VW-1:0] acc_sel;
    logic [VW-1:0] acc_next;

    // character classes
    assign diff      = i_text_byte - iotp_pkg::CHAR_ZERO;
    assign is_digit  = (diff <= iotp_pkg::DIGIT_MAX);
    assign is_colon  = (i_text_byte == iotp_pkg::CHAR_COLON);
    assign digit     = diff[DW-1:0];
    assign digit_ext = {{(VW - DW){1'b0}}, digit};

    // a begin mark restarts the scan with this byte
    assign cur_phase = i_begin_req ? iotp_pkg::PH_HOUR_FIRST : r_phase;
    assign cur_hour  = i_begin_req ? '0 : r_hour;
    assign cur_min   = i_begin_req ? '0 : r_min;
    assign cur_sec   = i_begin_req ? '0 : r_sec;
    assign cur_count = i_begin_req ? '0 : r_count;
    assign bumped    = (cur_count == iotp_pkg::COUNT_MAX) ? cur_count : cur_count + 1'b1;

    // one shared accumulate unit, fed by the field being extended
    always_comb begin
        case (cur_phase)
            iotp_pkg::PH_MIN_MORE: acc_sel = cur_min;
            iotp_pkg::PH_SEC_MORE: acc_sel = cur_sec;
            default:               acc_sel = cur_hour;
        endcase
    end

    iotp_digit_acc u_acc (
        .i_acc   (acc_sel),
        .i_digit (digit),
        .o_acc   (acc_next)
    );

    // next phase
    always_comb begin
        n_phase = cur_phase;
        unique case (cur_phase)
            iotp_pkg::PH_HOUR_FIRST:
                n_phase = is_digit ? iotp_pkg::PH_HOUR_MORE : iotp_pkg::PH_IDLE;
            iotp_pkg::PH_HOUR_MORE:
                if (!is_digit) begin
                    n_phase = is_colon ? iotp_pkg::PH_MIN_FIRST : iotp_pkg::PH_IDLE;
                end
            iotp_pkg::PH_MIN_FIRST:
                n_phase = is_digit ? iotp_pkg::PH_MIN_MORE : iotp_pkg::PH_IDLE;
            iotp_pkg::PH_MIN_MORE:
                if (!is_digit) begin
                    n_phase = is_colon ? iotp_pkg::PH_SEC_FIRST : iotp_pkg::PH_IDLE;
                end
            iotp_pkg::PH_SEC_FIRST:
                n_phase = is_digit ? iotp_pkg::PH_SEC_MORE : iotp_pkg::PH_IDLE;
            iotp_pkg::PH_SEC_MORE:
                if (!is_digit) begin
                    n_phase = iotp_pkg::PH_IDLE;
                end
            default:
                n_phase = iotp_pkg::PH_IDLE;
        endcase
    end

    // accumulator updates and result
    always_comb begin
        n_hour   = cur_hour;
        n_min    = cur_min;
        n_sec    = cur_sec;
        n_count  = cur_count;
        o_result = '0;
        unique case (cur_phase)
            iotp_pkg::PH_HOUR_FIRST: begin
                if (is_digit) begin
                    n_hour  = digit_ext;
                    n_count = bumped;
                end else begin
                    o_result.emit = 1'b1;
                end
            end
            iotp_pkg::PH_HOUR_MORE: begin
                if (is_digit) begin
                    n_hour  = acc_next;
                    n_count = bumped;
                end else if (is_colon) begin
                    n_count = bumped;
                end else begin
                    o_result.emit = 1'b1;
                end
            end
            iotp_pkg::PH_MIN_FIRST: begin
                if (is_digit) begin
                    n_min   = digit_ext;
                    n_count = bumped;
                end else begin
                    o_result.emit = 1'b1;
                end
            end
            iotp_pkg::PH_MIN_MORE: begin
                if (is_digit) begin
                    n_min   = acc_next;
                    n_count = bumped;
                end else if (is_colon) begin
                    n_count = bumped;
                end else begin
                    // time without seconds
                    n_sec            = '0;
                    o_result.emit    = 1'b1;
                    o_result.ok      = 1'b1;
                    o_result.hours   = cur_hour;
                    o_result.minutes = cur_min;
                    o_result.seconds = '0;
                    o_result.count   = cur_count;
                end
            end
            iotp_pkg::PH_SEC_FIRST: begin
                if (is_digit) begin
                    n_sec   = digit_ext;
                    n_count = bumped;
                end else begin
                    o_result.emit = 1'b1;
                end
            end
            iotp_pkg::PH_SEC_MORE: begin
                if (is_digit) begin
                    n_sec   = acc_next;
                    n_count = bumped;
                end else begin
                    o_result.emit    = 1'b1;
                    o_result.ok      = 1'b1;
                    o_result.hours   = cur_hour;
                    o_result.minutes = cur_min;
                    o_result.seconds = cur_sec;
                    o_result.count   = cur_count;
                end
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

    // scan state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= iotp_pkg::PH_HOUR_FIRST;
            r_hour  <= '0;
            r_min   <= '0;
            r_sec   <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_hour  <= n_hour;
            r_min   <= n_min;
            r_sec   <= n_sec;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/iso_time_of_day_parser_top.sv =====
// top level of the time-of-day parser: input handshake, scanner and result register
// depends on iotp_pkg and iotp_scan
//
// usage:
//   input channel carries one text byte per item with a begin flag that
//   restarts the scan on that byte. output channel carries one result item
//   (ok flag, hours, minutes, seconds, bytes consumed) per finished scan.
//   an item is taken at a clock edge with valid high and stall low.
// throughput and result timing:
//   one input item per cycle while o_stall is low. the byte that ends a scan
//   yields its result on the output in the cycle after it is accepted; only
//   the scanner's combinational decode of that byte against its stored
//   state sits between the accepted byte and the result register.
// stall behavior:
//   a held result keeps its value while i_stall is high; o_stall rises
//   only while a result is held and the receiver stalls, so new bytes keep
//   flowing whenever the result register is free or being emptied.
// reset:
//   synchronous, active low. the output empties and the scanner expects a
//   first hour digit at once, without a begin mark.
module iso_time_of_day_parser_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [7:0]                          i_text_byte,
    input  logic                                i_begin_req,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_time_ok,
    output logic [iotp_pkg::VALUE_WIDTH-1:0]    o_hours,
    output logic [iotp_pkg::VALUE_WIDTH-1:0]    o_minutes,
    output logic [iotp_pkg::VALUE_WIDTH-1:0]    o_seconds,
    output logic [iotp_pkg::COUNT_WIDTH-1:0]    o_bytes_scanned
);

    logic              accept;
    iotp_pkg::t_result result;

    logic                             r_out_valid;
    logic                             r_ok;
    logic [iotp_pkg::VALUE_WIDTH-1:0] r_hours;
    logic [iotp_pkg::VALUE_WIDTH-1:0] r_minutes;
    logic [iotp_pkg::VALUE_WIDTH-1:0] r_seconds;
    logic [iotp_pkg::COUNT_WIDTH-1:0] r_count;

    // input handshake
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    iotp_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_text_byte (i_text_byte),
        .i_begin_req (i_begin_req),
        .o_result    (result)
    );

    // result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && result.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept && result.emit) begin
            r_ok      <= result.ok;
            r_hours   <= result.hours;
            r_minutes <= result.minutes;
            r_seconds <= result.seconds;
            r_count   <= result.count;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_time_ok       = r_ok;
    assign o_hours         = r_hours;
    assign o_minutes       = r_minutes;
    assign o_seconds       = r_seconds;
    assign o_bytes_scanned = r_count;

endmodule

// ===== rtl/iotp_checker.sv =====
// port-level checks for the time-of-day parser, bound to the top level
// depends on iotp_pkg and iso_time_of_day_parser_top
module iotp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_stall,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic                             o_time_ok,
    input logic [iotp_pkg::VALUE_WIDTH-1:0] o_hours,
    input logic [iotp_pkg::VALUE_WIDTH-1:0] o_minutes,
    input logic [iotp_pkg::VALUE_WIDTH-1:0] o_seconds,
    input logic [iotp_pkg::COUNT_WIDTH-1:0] o_bytes_scanned
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_time_ok) && $stable(o_hours)
            && $stable(o_minutes) && $stable(o_seconds) && $stable(o_bytes_scanned))
        else $error("result changed while stalled");

    // input backs up only behind a held, stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    // a failed scan reports all zero fields
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_time_ok |-> o_hours == '0 && o_minutes == '0
            && o_seconds == '0 && o_bytes_scanned == '0)
        else $error("failed scan with nonzero fields");

    // a good time has at least a digit, a colon and a digit
    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_time_ok |-> o_bytes_scanned >= iotp_pkg::COUNT_WIDTH'(3))
        else $error("good time with too few bytes");

endmodule

bind iso_time_of_day_parser_top iotp_checker u_iotp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_time_ok       (o_time_ok),
    .o_hours         (o_hours),
    .o_minutes       (o_minutes),
    .o_seconds       (o_seconds),
    .o_bytes_scanned (o_bytes_scanned)
);

// ===== dv/iso_time_of_day_parser_checker.sv =====
// checker for the time-of-day parser: watches both channels, predicts each result
// item from the accepted text bytes and compares the received ones field by field
// depends on iotp_pkg
module iso_time_of_day_parser_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [7:0]                       i_text_byte,
    input  logic                             i_begin_req,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic                             i_time_ok,
    input  logic [iotp_pkg::VALUE_WIDTH-1:0] i_hours,
    input  logic [iotp_pkg::VALUE_WIDTH-1:0] i_minutes,
    input  logic [iotp_pkg::VALUE_WIDTH-1:0] i_seconds,
    input  logic [iotp_pkg::COUNT_WIDTH-1:0] i_bytes_scanned,
    output int                               o_fail_count,
    output int                               o_pending
);

    typedef struct packed {
        logic                             ok;
        logic [iotp_pkg::VALUE_WIDTH-1:0] hours;
        logic [iotp_pkg::VALUE_WIDTH-1:0] minutes;
        logic [iotp_pkg::VALUE_WIDTH-1:0] seconds;
        logic [iotp_pkg::COUNT_WIDTH-1:0] count;
    } t_time_result;

    // scan state of the predictor
    iotp_pkg::t_phase                 scan_phase;
    logic [iotp_pkg::VALUE_WIDTH-1:0] hour_acc;
    logic [iotp_pkg::VALUE_WIDTH-1:0] minute_acc;
    logic [iotp_pkg::VALUE_WIDTH-1:0] second_acc;
    logic [iotp_pkg::COUNT_WIDTH-1:0] byte_count;

    t_time_result expected_times[$];
    int           mismatch_count = 0;
    int           waiting_count  = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = waiting_count;

    // acc * 10 + digit, held at the top of the value range
    function automatic logic [iotp_pkg::VALUE_WIDTH-1:0] shift_in_digit(
        input logic [iotp_pkg::VALUE_WIDTH-1:0] acc,
        input logic [7:0]                       digit
    );
        longint unsigned sum;
        sum = acc;
        sum = sum * 10 + digit;
        return (sum > iotp_pkg::VALUE_MAX) ? iotp_pkg::VALUE_MAX
                                           : sum[iotp_pkg::VALUE_WIDTH-1:0];
    endfunction

    task automatic clear_scan();
        scan_phase = iotp_pkg::PH_HOUR_FIRST;
        hour_acc   = '0;
        minute_acc = '0;
        second_acc = '0;
        byte_count = '0;
    endtask

    task automatic count_byte();
        if (byte_count != iotp_pkg::COUNT_MAX) begin
            byte_count = byte_count + 1'b1;
        end
    endtask

    // queue the time (or an all-zero failure) and wait for the next begin mark
    task automatic finish_scan(input logic ok);
        t_time_result res;
        res.ok      = ok;
        res.hours   = ok ? hour_acc : '0;
        res.minutes = ok ? minute_acc : '0;
        res.seconds = ok ? second_acc : '0;
        res.count   = ok ? byte_count : '0;
        expected_times.push_back(res);
        scan_phase = iotp_pkg::PH_IDLE;
    endtask

    // advance the predicted scan by one accepted text byte
    task automatic scan_byte(input logic [7:0] ch, input logic bgn);
        logic [7:0] digit;
        logic       is_digit;
        logic       is_colon;
        digit    = ch - iotp_pkg::CHAR_ZERO;
        is_digit = digit <= iotp_pkg::DIGIT_MAX;
        is_colon = ch == iotp_pkg::CHAR_COLON;
        if (bgn) begin
            clear_scan();
        end
        case (scan_phase)
            iotp_pkg::PH_HOUR_FIRST: begin
                if (!is_digit) begin
                    finish_scan(1'b0);
                end else begin
                    hour_acc = iotp_pkg::VALUE_WIDTH'(digit);
                    count_byte();
                    scan_phase = iotp_pkg::PH_HOUR_MORE;
                end
            end
            iotp_pkg::PH_HOUR_MORE: begin
                if (is_digit) begin
                    hour_acc = shift_in_digit(hour_acc, digit);
                    count_byte();
                end else if (!is_colon) begin
                    finish_scan(1'b0);
                end else begin
                    count_byte();
                    scan_phase = iotp_pkg::PH_MIN_FIRST;
                end
            end
            iotp_pkg::PH_MIN_FIRST: begin
                if (!is_digit) begin
                    finish_scan(1'b0);
                end else begin
                    minute_acc = iotp_pkg::VALUE_WIDTH'(digit);
                    count_byte();
                    scan_phase = iotp_pkg::PH_MIN_MORE;
                end
            end
            iotp_pkg::PH_MIN_MORE: begin
                if (is_digit) begin
                    minute_acc = shift_in_digit(minute_acc, digit);
                    count_byte();
                end else if (!is_colon) begin
                    second_acc = '0;
                    finish_scan(1'b1);
                end else begin
                    count_byte();
                    scan_phase = iotp_pkg::PH_SEC_FIRST;
                end
            end
            iotp_pkg::PH_SEC_FIRST: begin
                if (!is_digit) begin
                    finish_scan(1'b0);
                end else begin
                    second_acc = iotp_pkg::VALUE_WIDTH'(digit);
                    count_byte();
                    scan_phase = iotp_pkg::PH_SEC_MORE;
                end
            end
            iotp_pkg::PH_SEC_MORE: begin
                if (is_digit) begin
                    second_acc = shift_in_digit(second_acc, digit);
                    count_byte();
                end else begin
                    finish_scan(1'b1);
                end
            end
            default: ;
        endcase
    endtask

    // results first: a result at this edge belongs to an earlier byte
    always @(posedge i_clk) begin
        t_time_result want;
        if (!i_rst_n) begin
            clear_scan();
            expected_times.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_times.size() == 0) begin
                    $error("result item with nothing expected: ok %0d hours %0d minutes %0d",
                           i_time_ok, i_hours, i_minutes);
                    mismatch_count++;
                end else begin
                    want = expected_times.pop_front();
                    if (i_time_ok !== want.ok) begin
                        $error("time_ok: expected %0d, got %0d", want.ok, i_time_ok);
                        mismatch_count++;
                    end
                    if (i_hours !== want.hours) begin
                        $error("hours: expected %0d, got %0d", want.hours, i_hours);
                        mismatch_count++;
                    end
                    if (i_minutes !== want.minutes) begin
                        $error("minutes: expected %0d, got %0d", want.minutes, i_minutes);
                        mismatch_count++;
                    end
                    if (i_seconds !== want.seconds) begin
                        $error("seconds: expected %0d, got %0d", want.seconds, i_seconds);
                        mismatch_count++;
                    end
                    if (i_bytes_scanned !== want.count) begin
                        $error("bytes_scanned: expected %0d, got %0d",
                               want.count, i_bytes_scanned);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                scan_byte(i_text_byte, i_begin_req);
            end
        end
        waiting_count = expected_times.size();
    end

endmodule

// ===== dv/iso_time_of_day_parser_top_tb.sv =====
// testbench top for the time-of-day parser: clock, reset, text stimulus and verdict
// depends on iotp_pkg, iso_time_of_day_parser_top and iso_time_of_day_parser_checker
module iso_time_of_day_parser_top_tb;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_valid     = 1'b0;
    logic [7:0]                       i_text_byte = '0;
    logic                             i_begin_req = 1'b0;
    logic                             i_stall     = 1'b0;
    logic                             o_stall;
    logic                             o_valid;
    logic                             o_time_ok;
    logic [iotp_pkg::VALUE_WIDTH-1:0] o_hours;
    logic [iotp_pkg::VALUE_WIDTH-1:0] o_minutes;
    logic [iotp_pkg::VALUE_WIDTH-1:0] o_seconds;
    logic [iotp_pkg::COUNT_WIDTH-1:0] o_bytes_scanned;

    int         fail_count;
    int         pending_results;
    int         items_sent = 0;
    int         idle_pct   = 0;
    int         stall_pct  = 0;
    logic [7:0] text_q[$];

    iso_time_of_day_parser_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_text_byte     (i_text_byte),
        .i_begin_req     (i_begin_req),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_time_ok       (o_time_ok),
        .o_hours         (o_hours),
        .o_minutes       (o_minutes),
        .o_seconds       (o_seconds),
        .o_bytes_scanned (o_bytes_scanned)
    );

    iso_time_of_day_parser_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_text_byte     (i_text_byte),
        .i_begin_req     (i_begin_req),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_time_ok       (o_time_ok),
        .i_hours         (o_hours),
        .i_minutes       (o_minutes),
        .i_seconds       (o_seconds),
        .i_bytes_scanned (o_bytes_scanned),
        .o_fail_count    (fail_count),
        .o_pending       (pending_results)
    );

    // clock, period 8
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_stall = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // hard limit on run length
    initial begin
        #2_000_000;
        $display("iso_time_of_day_parser_top_tb: FAIL");
        $finish;
    end

    // one item: optional sender gaps, then hold until accepted
    task automatic send_byte(input logic [7:0] b, input logic bgn);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_text_byte = b;
        i_begin_req = bgn;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_text(input string s, input logic bgn);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], bgn && i == 0);
        end
    endtask

    task automatic push_digits(input int n);
        repeat (n) text_q.push_back(iotp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
    endtask

    // random byte that is not a digit, and optionally not a colon either
    function automatic logic [7:0] pick_stop_byte(input logic colon_ok);
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while ((b >= iotp_pkg::CHAR_ZERO && b <= iotp_pkg::CHAR_ZERO + iotp_pkg::DIGIT_MAX)
               || (!colon_ok && b == iotp_pkg::CHAR_COLON));
        return b;
    endfunction

    function automatic int pick_field_len();
        return ($urandom_range(9) < 8) ? $urandom_range(1, 2) : $urandom_range(3, 7);
    endfunction

    // well-formed hh:mm[:ss] followed by its stop byte
    task automatic build_time(input logic long_hours);
        text_q.delete();
        if (long_hours) begin
            repeat ($urandom_range(255, 270)) text_q.push_back(iotp_pkg::CHAR_ZERO);
            push_digits(1);
        end else begin
            push_digits(pick_field_len());
        end
        text_q.push_back(iotp_pkg::CHAR_COLON);
        push_digits(pick_field_len());
        if ($urandom_range(1)) begin
            text_q.push_back(iotp_pkg::CHAR_COLON);
            push_digits(pick_field_len());
            text_q.push_back(pick_stop_byte(1'b1));
        end else begin
            text_q.push_back(pick_stop_byte(1'b0));
        end
    endtask

    task automatic send_queue();
        foreach (text_q[i]) send_byte(text_q[i], i == 0);
    endtask

    initial begin
        int seq_num;
        int kind;
        int idx;
        seq_num = 0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: scan right after reset without a begin mark, zero byte ends it
        send_text("1:2", 1'b0);
        send_byte(8'h00, 1'b0);
        // ignored after a result
        send_byte("7", 1'b0);
        // hours saturate, seconds ended by a colon
        send_text("99999:0:9:", 1'b1);
        // missing hour digit, missing colon, missing minute digit
        send_text(":", 1'b1);
        send_text("5;", 1'b1);
        send_text("1:/", 1'b1);
        // begin mark mid-scan drops it; then colon after minutes with no digit
        send_text("4:5", 1'b1);
        send_text("2:3::", 1'b1);
        send_byte(8'hff, 1'b1);

        // random sequences through the idling phases
        while (items_sent < 1700) begin
            case ((items_sent / 200) % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 47; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 47; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            seq_num++;
            kind = $urandom_range(99);
            if (kind < 75) begin
                build_time(seq_num % 150 == 149);
            end else if (kind < 90) begin
                build_time(1'b0);
                idx = $urandom_range(text_q.size() - 1);
                if ($urandom_range(1)) begin
                    text_q[idx] = 8'($urandom_range(255));
                end else begin
                    while (text_q.size() > idx + 1) void'(text_q.pop_back());
                end
            end else begin
                text_q.delete();
                repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(255)));
            end
            send_queue();
            // trailing bytes, ignored once the scan has finished
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
            end
            // stray begin marks inside noise
            if (kind >= 90 && $urandom_range(1)) begin
                send_byte(8'($urandom_range(255)), 1'b1);
            end
        end
        i_valid = 1'b0;

        // drain, then keep watching the output for stray results before the verdict
        while (pending_results != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("iso_time_of_day_parser_top_tb: PASS");
        end else begin
            $display("iso_time_of_day_parser_top_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/iotp_pkg.sv
rtl/iotp_digit_acc.sv
rtl/iotp_scan.sv
rtl/iso_time_of_day_parser_top.sv
rtl/iotp_checker.sv
dv/iso_time_of_day_parser_checker.sv
dv/iso_time_of_day_parser_top_tb.sv
